// ----- rtl/uidt_pkg.sv -----
`timescale 1ns / 1ps

package uidt_pkg;

    localparam int UID_W = 48;
    localparam int POS_W = 8;
    localparam int ENT_W = 9;
    localparam int REQ_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_UNIQUE = 3'd0,
        REQ_PUSH       = 3'd1,
        REQ_POP        = 3'd2,
        REQ_REMOVE_AT  = 3'd3,
        REQ_READ_AT    = 3'd4,
        REQ_CONTAINS   = 3'd5,
        REQ_CLEAR      = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // per-cycle command broadcast along the chain
    typedef struct packed {
        logic load;
        logic shift;
    } cell_cmd_t;

endpackage

// ----- rtl/unique_id_table.sv -----
`timescale 1ns / 1ps
// Flow: an accepted request passes the SCAN and DONE states, and its result is registered on leaving DONE.
// A new request is taken only in IDLE, after the last result; a held result stalls the final step.
// All entries are compared and selected in parallel by the cell row, reduced over
// registered groups of 32 cells.
// Reset: asynchronous, clears the entry count and the valid flags; stored ids are kept.

module unique_id_table #(
    parameter int CAPACITY = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [uidt_pkg::REQ_W-1:0]  req_type,
    input  logic [uidt_pkg::UID_W-1:0]  uid_in,
    input  logic [uidt_pkg::POS_W-1:0]  position,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        ok,
    output logic [uidt_pkg::UID_W-1:0]  uid_out,
    output logic [uidt_pkg::ENT_W-1:0]  entries
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > uidt_pkg::POS_W) ? CNT_W : uidt_pkg::POS_W;
    localparam int GROUP   = 32;
    localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    uidt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    logic [uidt_pkg::REQ_W-1:0] kind_reg;
    logic [uidt_pkg::UID_W-1:0] uid_reg;
    logic [uidt_pkg::POS_W-1:0] pos_reg;
    logic                       ok_reg, ok_next;
    logic [uidt_pkg::UID_W-1:0] uid_out_reg, uid_out_next;
    logic [uidt_pkg::ENT_W-1:0] ent_reg, ent_next;

    logic                accept;
    logic                scan;
    logic                apply;
    uidt_pkg::cell_cmd_t cmd;
    logic [CNT_W-1:0]    target;
    logic                found;
    logic [uidt_pkg::UID_W-1:0] picked;
    logic                full;
    logic                pos_ok;

    logic [NGROUPS-1:0]         grp_hit;
    logic [uidt_pkg::UID_W-1:0] grp_data  [NGROUPS];
    logic [uidt_pkg::UID_W-1:0] grp_first [NGROUPS];

    // state machine
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uidt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = uidt_pkg::ST_SCAN;
                end
            end
            uidt_pkg::ST_SCAN:
            begin
                state_next = uidt_pkg::ST_DONE;
            end
            uidt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    state_next = uidt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uidt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        scan      = 1'b0;
        apply     = 1'b0;
        case (state_reg)
            uidt_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            uidt_pkg::ST_SCAN:
            begin
                scan = 1'b1;
            end
            uidt_pkg::ST_DONE:
            begin
                apply = !out_valid_reg || !res_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept = req_valid && !req_stall;

    // cell row
    assign full   = count_reg >= CAP_CNT;
    assign pos_ok = CMP_W'(pos_reg) < CMP_W'(count_reg);

    always_comb
    begin
        if (uidt_pkg::req_t'(kind_reg) == uidt_pkg::REQ_POP)
        begin
            target = count_reg - ONE_CNT;
        end
        else
        begin
            target = CNT_W'(pos_reg);
        end
    end

    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_grp
        localparam int SZ = (CAPACITY - g * GROUP < GROUP) ? (CAPACITY - g * GROUP) : GROUP;
        logic [uidt_pkg::UID_W-1:0] nxt;

        if (g + 1 < NGROUPS)
        begin : g_mid
            assign nxt = grp_first[g+1];
        end
        else
        begin : g_end
            assign nxt = '0;
        end

        uidt_group #(
            .CAPACITY (CAPACITY),
            .BASE     (g * GROUP),
            .SIZE     (SZ)
        ) u_group (
            .clk       (clk),
            .cmd       (cmd),
            .scan      (scan),
            .count     (count_reg),
            .target    (target),
            .uid       (uid_reg),
            .next_in   (nxt),
            .first_out (grp_first[g]),
            .hit       (grp_hit[g]),
            .data      (grp_data[g])
        );
    end

    always_comb
    begin
        picked = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            picked = picked | grp_data[g];
        end
    end

    assign found = |grp_hit;

    // request decode
    always_comb
    begin
        cmd          = '0;
        count_next   = count_reg;
        ok_next      = 1'b0;
        uid_out_next = '0;
        case (uidt_pkg::req_t'(kind_reg))
            uidt_pkg::REQ_ADD_UNIQUE:
            begin
                if (!found && !full)
                begin
                    cmd.load   = 1'b1;
                    count_next = count_reg + ONE_CNT;
                    ok_next    = 1'b1;
                end
            end
            uidt_pkg::REQ_PUSH:
            begin
                if (!full)
                begin
                    cmd.load   = 1'b1;
                    count_next = count_reg + ONE_CNT;
                    ok_next    = 1'b1;
                end
            end
            uidt_pkg::REQ_POP:
            begin
                if (count_reg != '0)
                begin
                    count_next   = count_reg - ONE_CNT;
                    ok_next      = 1'b1;
                    uid_out_next = picked;
                end
            end
            uidt_pkg::REQ_REMOVE_AT:
            begin
                if (pos_ok)
                begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - ONE_CNT;
                    ok_next    = 1'b1;
                end
            end
            uidt_pkg::REQ_READ_AT:
            begin
                if (pos_ok)
                begin
                    ok_next      = 1'b1;
                    uid_out_next = picked;
                end
            end
            uidt_pkg::REQ_CONTAINS:
            begin
                ok_next = found;
            end
            uidt_pkg::REQ_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        if (!apply)
        begin
            cmd        = '0;
            count_next = count_reg;
        end
    end

    assign ent_next = uidt_pkg::ENT_W'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg && res_stall;
        if (apply)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uidt_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req_type;
            uid_reg  <= uid_in;
            pos_reg  <= position;
        end
        if (apply)
        begin
            ok_reg      <= ok_next;
            uid_out_reg <= uid_out_next;
            ent_reg     <= ent_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign uid_out   = uid_out_reg;
    assign entries   = ent_reg;

endmodule

// ----- rtl/uidt_cell.sv -----
`timescale 1ns / 1ps

module uidt_cell #(
    parameter int CAPACITY = 256,
    parameter int INDEX    = 0
) (
    input  logic                     clk,
    input  uidt_pkg::cell_cmd_t      cmd,
    input  logic [$clog2(CAPACITY+1)-1:0] count,
    input  logic [$clog2(CAPACITY+1)-1:0] target,
    input  logic [uidt_pkg::UID_W-1:0]    uid,
    input  logic [uidt_pkg::UID_W-1:0]    next_id,
    output logic [uidt_pkg::UID_W-1:0]    id,
    output logic                          hit,
    output logic [uidt_pkg::UID_W-1:0]    sel_id
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

    logic [uidt_pkg::UID_W-1:0] id_reg;
    logic [uidt_pkg::UID_W-1:0] id_next;
    logic                       occupied;

    assign occupied = IDX < count;
    assign hit      = occupied && (id_reg == uid);
    assign sel_id   = (IDX == target) ? id_reg : '0;
    assign id       = id_reg;

    always_comb
    begin
        id_next = id_reg;
        if (cmd.load && (IDX == count))
        begin
            id_next = uid;
        end
        else if (cmd.shift && (IDX >= target) && (IDX1 < count))
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

// ----- rtl/uidt_group.sv -----
`timescale 1ns / 1ps

module uidt_group #(
    parameter int CAPACITY = 256,
    parameter int BASE     = 0,
    parameter int SIZE     = 32
) (
    input  logic                          clk,
    input  uidt_pkg::cell_cmd_t           cmd,
    input  logic                          scan,
    input  logic [$clog2(CAPACITY+1)-1:0] count,
    input  logic [$clog2(CAPACITY+1)-1:0] target,
    input  logic [uidt_pkg::UID_W-1:0]    uid,
    input  logic [uidt_pkg::UID_W-1:0]    next_in,
    output logic [uidt_pkg::UID_W-1:0]    first_out,
    output logic                          hit,
    output logic [uidt_pkg::UID_W-1:0]    data
);

    logic [uidt_pkg::UID_W-1:0] chain [SIZE+1];
    logic [uidt_pkg::UID_W-1:0] sel   [SIZE];
    logic [SIZE-1:0]            hits;
    logic [uidt_pkg::UID_W-1:0] data_any;
    logic                       hit_reg;
    logic [uidt_pkg::UID_W-1:0] data_reg;

    assign chain[SIZE] = next_in;
    assign first_out   = chain[0];

    for (genvar k = 0; k < SIZE; k++)
    begin : g_cell
        uidt_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (BASE + k)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .count   (count),
            .target  (target),
            .uid     (uid),
            .next_id (chain[k+1]),
            .id      (chain[k]),
            .hit     (hits[k]),
            .sel_id  (sel[k])
        );
    end

    always_comb
    begin
        data_any = '0;
        for (int k = 0; k < SIZE; k++)
        begin
            data_any = data_any | sel[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan)
        begin
            hit_reg  <= |hits;
            data_reg <= data_any;
        end
    end

    assign hit  = hit_reg;
    assign data = data_reg;

endmodule

// ----- tb/sv/uid_table_checker.sv -----
`timescale 1ns / 1ps

module uid_table_checker
    import uidt_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_stall,
    input  logic [REQ_W-1:0] req_type,
    input  logic [UID_W-1:0] uid_in,
    input  logic [POS_W-1:0] position,
    input  logic             res_valid,
    input  logic             res_stall,
    input  logic             ok,
    input  logic [UID_W-1:0] uid_out,
    input  logic [ENT_W-1:0] entries,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic             ok;
        logic [UID_W-1:0] uid;
        logic [ENT_W-1:0] entries;
    } table_reply_t;

    logic [UID_W-1:0] held_ids [DEPTH];
    int               held_count;
    table_reply_t     awaited_replies [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        held_count = 0;
    end

    function automatic bit holds_id(input logic [UID_W-1:0] id);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_ids[i] == id)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic table_reply_t apply_request(input logic [REQ_W-1:0] kind,
                                                   input logic [UID_W-1:0] id,
                                                   input logic [POS_W-1:0] pos);
        table_reply_t r;
        int           idx;
        r   = '0;
        idx = int'(pos);
        case (kind)
            REQ_ADD_UNIQUE:
            begin
                if (!holds_id(id) && held_count < DEPTH)
                begin
                    held_ids[held_count] = id;
                    held_count++;
                    r.ok = 1'b1;
                end
            end
            REQ_PUSH:
            begin
                if (held_count < DEPTH)
                begin
                    held_ids[held_count] = id;
                    held_count++;
                    r.ok = 1'b1;
                end
            end
            REQ_POP:
            begin
                if (held_count > 0)
                begin
                    held_count--;
                    r.uid = held_ids[held_count];
                    r.ok  = 1'b1;
                end
            end
            REQ_REMOVE_AT:
            begin
                if (idx < held_count)
                begin
                    for (int i = idx; i + 1 < held_count; i++)
                        held_ids[i] = held_ids[i + 1];
                    held_count--;
                    r.ok = 1'b1;
                end
            end
            REQ_READ_AT:
            begin
                if (idx < held_count)
                begin
                    r.uid = held_ids[idx];
                    r.ok  = 1'b1;
                end
            end
            REQ_CONTAINS:
                r.ok = holds_id(id);
            REQ_CLEAR:
            begin
                held_count = 0;
                r.ok       = 1'b1;
            end
            default:
                r.ok = 1'b0;
        endcase
        r.entries = ENT_W'(held_count);
        return r;
    endfunction

    always @(posedge clk)
    begin
        table_reply_t got;
        table_reply_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                awaited_replies.push_back(apply_request(req_type, uid_in, position));
            if (res_valid && !res_stall)
            begin
                got = '{ok: ok, uid: uid_out, entries: entries};
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply ok=%0b uid=%h entries=%0d",
                             $realtime, got.ok, got.uid, got.entries);
                    fail_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: reply mismatch, expected ok=%0b uid=%h entries=%0d",
                                 $realtime, want.ok, want.uid, want.entries);
                        $display("%0t:                 actual   ok=%0b uid=%h entries=%0d",
                                 $realtime, got.ok, got.uid, got.entries);
                        fail_count++;
                    end
                end
            end
            pending = awaited_replies.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import uidt_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int ITEM_TARGET  = 1350;
    localparam int QUIET_FROM   = 1200;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam logic [UID_W-1:0] UID_ONES   = '1;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [REQ_W-1:0] req_type;
    logic [UID_W-1:0] uid_in;
    logic [POS_W-1:0] position;
    logic             res_valid;
    logic             res_stall;
    logic             ok;
    logic [UID_W-1:0] uid_out;
    logic [ENT_W-1:0] entries;

    int               fail_count;
    int               pending;
    int               cycles;
    int               sent;
    bit               req_idling;
    bit               res_idling;
    logic [UID_W-1:0] id_pool [16];

    unique_id_table #(
        .CAPACITY(TABLE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .uid_in(uid_in),
        .position(position),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .ok(ok),
        .uid_out(uid_out),
        .entries(entries)
    );

    uid_table_checker #(
        .DEPTH(TABLE_DEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .uid_in(uid_in),
        .position(position),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .ok(ok),
        .uid_out(uid_out),
        .entries(entries),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (res_idling && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic logic [UID_W-1:0] fresh_uid();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[UID_W-1:0];
    endfunction

    function automatic logic [UID_W-1:0] pick_uid();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return id_pool[$urandom_range(0, 15)];
        else if (r == 9)
            return '0;
        else if (r == 10)
            return UID_ONES;
        return fresh_uid();
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return POS_W'($urandom_range(0, 15));
        else if (r < 9)
            return POS_W'($urandom_range(0, 63));
        return POS_W'($urandom_range(0, 255));
    endfunction

    // entered just after a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input logic [REQ_W-1:0] kind,
                            input logic [UID_W-1:0] id,
                            input logic [POS_W-1:0] pos);
        if (req_idling && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        uid_in    <= id;
        position  <= pos;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (kind == REQ_PUSH || kind == REQ_ADD_UNIQUE)
            id_pool[$urandom_range(0, 15)] = id;
        sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int                scenario;
        int                r;
        logic [REQ_W-1:0]  kind;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_type   = REQ_ADD_UNIQUE;
        uid_in     = '0;
        position   = '0;
        sent       = 0;
        req_idling = 1'b1;
        res_idling = 1'b1;
        for (int i = 0; i < 16; i++)
            id_pool[i] = fresh_uid();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, unused code, duplicates, range limits
        send_req(REQ_POP,        '0,        8'd0);
        send_req(REQ_READ_AT,    '0,        8'd0);
        send_req(REQ_REMOVE_AT,  '0,        8'd0);
        send_req(REQ_CONTAINS,   '0,        8'd0);
        send_req(REQ_UNUSED,     UID_ONES,  8'd255);
        send_req(REQ_ADD_UNIQUE, '0,        8'd0);
        send_req(REQ_ADD_UNIQUE, UID_ONES,  8'd255);
        send_req(REQ_ADD_UNIQUE, UID_ONES,  8'd0);
        send_req(REQ_PUSH,       UID_ONES,  8'd0);
        send_req(REQ_CONTAINS,   UID_ONES,  8'd0);
        send_req(REQ_CONTAINS,   48'h5555_5555_5555, 8'd0);
        send_req(REQ_UNUSED,     '0,        8'd0);
        send_req(REQ_READ_AT,    '0,        8'd0);
        send_req(REQ_READ_AT,    '0,        8'd2);
        send_req(REQ_READ_AT,    '0,        8'd255);
        send_req(REQ_REMOVE_AT,  '0,        8'd1);
        send_req(REQ_READ_AT,    '0,        8'd1);
        send_req(REQ_REMOVE_AT,  '0,        8'd3);
        send_req(REQ_POP,        '0,        8'd0);
        send_req(REQ_POP,        '0,        8'd0);
        send_req(REQ_POP,        '0,        8'd0);
        send_req(REQ_CLEAR,      '0,        8'd0);
        send_req(REQ_PUSH,       48'hAAAA_AAAA_AAAA, 8'd0);
        send_req(REQ_CLEAR,      '0,        8'd0);

        // fill to capacity, then work at the full boundary
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_req(($urandom_range(0, 1) != 0) ? REQ_PUSH : REQ_ADD_UNIQUE,
                     fresh_uid(), pick_pos());
        send_req(REQ_PUSH,       fresh_uid(), 8'd0);
        send_req(REQ_ADD_UNIQUE, fresh_uid(), 8'd0);
        send_req(REQ_CONTAINS,   pick_uid(),  8'd0);
        send_req(REQ_READ_AT,    '0,          8'd255);
        send_req(REQ_READ_AT,    '0,          8'd0);
        send_req(REQ_REMOVE_AT,  '0,          8'd255);
        send_req(REQ_PUSH,       UID_ONES,    8'd0);
        send_req(REQ_REMOVE_AT,  '0,          8'd0);
        send_req(REQ_POP,        '0,          8'd0);

        while (sent < ITEM_TARGET)
        begin
            if (sent >= QUIET_FROM)
            begin
                req_idling = 1'b0;
                res_idling = 1'b0;
            end
            else
            begin
                req_idling = ($urandom_range(0, 3) != 0);
                res_idling = ($urandom_range(0, 3) != 0);
            end
            scenario = $urandom_range(0, 9);
            repeat ($urandom_range(5, 40))
            begin
                r = $urandom_range(0, 19);
                if (scenario < 4)
                    kind = (r < 9) ? REQ_PUSH : (r < 18) ? REQ_ADD_UNIQUE : REQ_CONTAINS;
                else if (scenario < 8)
                begin
                    case (r)
                        0, 1, 2, 3:  kind = REQ_ADD_UNIQUE;
                        4, 5:        kind = REQ_PUSH;
                        6, 7:        kind = REQ_POP;
                        8, 9, 10:    kind = REQ_REMOVE_AT;
                        11, 12, 13:  kind = REQ_READ_AT;
                        14, 15, 16,
                        17:          kind = REQ_CONTAINS;
                        18:          kind = ($urandom_range(0, 3) == 0) ? REQ_CLEAR
                                                                        : REQ_READ_AT;
                        default:     kind = REQ_UNUSED;
                    endcase
                end
                else
                    kind = (r < 10) ? REQ_POP : REQ_REMOVE_AT;
                send_req(kind, pick_uid(), pick_pos());
            end
        end

        req_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
